FILE: hw/rtl/cef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle event package
// Shared widths, the status codes and the transfer types of the circle event
// block.
// ----------------------------------------------------------------------------
package cef_pkg;

    localparam int COORD_BITS = 32;
    localparam int LIMB_BITS  = 32;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LEFT      = 2'd1,
        ST_COLLINEAR = 2'd2,
        ST_SAT       = 2'd3
    } t_cef_status;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
    } t_cef_in;

    typedef struct packed {
        t_cef_status status;
        t_coord      center_x;
        t_coord      center_y;
        t_coord      event_x;
    } t_cef_out;

endpackage
`default_nettype wire

FILE: hw/rtl/circle_event_from_three_sites.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle event from three sites
// Circumcenter of three fixed-point sites and the rightmost x of their circle.
//
// A triple is taken on i_item in each cycle in which start is high; busy is
// never raised, so a new transfer may follow in every cycle. Each triple
// yields exactly one result, shown on o_result for one cycle with o_valid
// high, in the order the triples came in.
// The pipeline runs through the two quotient dividers and the square root,
// which settle one result bit per stage, and the limb multipliers that form
// the cross products, the numerators and the squared offsets. Throughput is
// one triple per cycle. Triples with a left turn or collinear sites report
// that status with zero coordinates; coordinates that leave the signed range
// saturate with the saturated status. A synchronous reset empties the
// pipeline: no result is shown for triples taken before it. The receiver
// cannot hold results off.
// ----------------------------------------------------------------------------
module circle_event_from_three_sites
    import cef_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_cef_in  i_item,
    output logic     o_valid,
    output t_cef_out o_result
);

    localparam int W   = COORD_BITS;
    localparam int DFW = W + 1;
    localparam int MPW = 2 * DFW;
    localparam int KW  = 2 * W + 3;
    localparam int PQW = 2 * W + 3;
    localparam int M2W = DFW + PQW;
    localparam int NNW = 3 * W + 5;
    localparam int TW  = 3 * W + 6;
    localparam int DNW = 2 * W + 4;
    localparam int DXW = 3 * W + 3;
    localparam int XW  = 2 * DXW;
    localparam int RW  = XW / 2;
    localparam int OW  = DXW + 1;
    localparam int EXW = 3 * W + 5;

    typedef logic signed [DFW-1:0] t_dif;
    typedef logic signed [DXW-1:0] t_off;
    typedef logic signed [OW-1:0]  t_ctr;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_dif   a;
        t_dif   b;
        t_dif   c;
        t_dif   d;
    } t_sb1;

    typedef struct packed {
        t_coord                ax;
        t_coord                ay;
        logic signed [KW-1:0]  k;
        t_cef_status           rej;
    } t_sb2;

    typedef struct packed {
        t_coord      ax;
        t_coord      ay;
        t_cef_status rej;
    } t_sb3;

    typedef struct packed {
        t_coord      ax;
        t_coord      ay;
        t_cef_status rej;
        logic        negx;
        logic        negy;
    } t_sb4;

    typedef struct packed {
        t_coord      ax;
        t_coord      ay;
        t_cef_status rej;
        t_off        dx;
        t_off        dy;
    } t_sb5;

    typedef struct packed {
        t_ctr        ox;
        t_ctr        oy;
        t_cef_status rej;
    } t_sb6;

    function automatic logic [W:0] f_clamp(input logic signed [EXW-1:0] v);
        logic [W:0] res;
        if ((&v[EXW-1:W-1]) || !(|v[EXW-1:W-1])) begin
            res = {1'b0, v[W-1:0]};
        end else if (v[EXW-1]) begin
            res = {1'b1, 1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(W-1){1'b1}}};
        end
        return res;
    endfunction

    // Input and difference stages.
    logic    r0_vld;
    t_cef_in r0_in;
    logic    r1_vld;
    t_sb1    r1_sb;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_in    <= i_item;
        r1_sb.ax <= r0_in.ax;
        r1_sb.ay <= r0_in.ay;
        r1_sb.a  <= DFW'(r0_in.bx) - DFW'(r0_in.ax);
        r1_sb.b  <= DFW'(r0_in.by) - DFW'(r0_in.ay);
        r1_sb.c  <= DFW'(r0_in.cx) - DFW'(r0_in.ax);
        r1_sb.d  <= DFW'(r0_in.cy) - DFW'(r0_in.ay);
    end

    // Cross product and squared lengths.
    logic                  w_vld1;
    t_sb1                  w_sb1;
    logic signed [MPW-1:0] w_ad;
    logic signed [MPW-1:0] w_bc;
    logic signed [MPW-1:0] w_aa;
    logic signed [MPW-1:0] w_bb;
    logic signed [MPW-1:0] w_cc;
    logic signed [MPW-1:0] w_dd;

    cef_mul #(.AW(DFW), .BW(DFW), .SW($bits(t_sb1))) u_mul_ad (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r1_vld),
        .i_a(r1_sb.a), .i_b(r1_sb.d), .i_side(r1_sb),
        .o_vld(w_vld1), .o_p(w_ad), .o_side(w_sb1)
    );
    cef_mul #(.AW(DFW), .BW(DFW), .SW(1)) u_mul_bc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r1_vld),
        .i_a(r1_sb.b), .i_b(r1_sb.c), .i_side(1'b0),
        .o_vld(), .o_p(w_bc), .o_side()
    );
    cef_mul #(.AW(DFW), .BW(DFW), .SW(1)) u_mul_aa (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r1_vld),
        .i_a(r1_sb.a), .i_b(r1_sb.a), .i_side(1'b0),
        .o_vld(), .o_p(w_aa), .o_side()
    );
    cef_mul #(.AW(DFW), .BW(DFW), .SW(1)) u_mul_bb (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r1_vld),
        .i_a(r1_sb.b), .i_b(r1_sb.b), .i_side(1'b0),
        .o_vld(), .o_p(w_bb), .o_side()
    );
    cef_mul #(.AW(DFW), .BW(DFW), .SW(1)) u_mul_cc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r1_vld),
        .i_a(r1_sb.c), .i_b(r1_sb.c), .i_side(1'b0),
        .o_vld(), .o_p(w_cc), .o_side()
    );
    cef_mul #(.AW(DFW), .BW(DFW), .SW(1)) u_mul_dd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r1_vld),
        .i_a(r1_sb.d), .i_b(r1_sb.d), .i_side(1'b0),
        .o_vld(), .o_p(w_dd), .o_side()
    );

    logic                  r2_vld;
    logic signed [KW-1:0]  r2_k;
    logic signed [PQW-1:0] r2_p;
    logic signed [PQW-1:0] r2_q;
    t_sb1                  r2_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= w_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_k  <= KW'(w_ad) - KW'(w_bc);
        r2_p  <= {1'b0, w_aa} + {1'b0, w_bb};
        r2_q  <= {1'b0, w_cc} + {1'b0, w_dd};
        r2_sb <= w_sb1;
    end

    // Orientation check and numerators.
    t_sb2 n_sb2;

    always_comb begin
        n_sb2.ax = r2_sb.ax;
        n_sb2.ay = r2_sb.ay;
        n_sb2.k  = r2_k;
        if (r2_k == '0) begin
            n_sb2.rej = ST_COLLINEAR;
        end else if (!r2_k[KW-1]) begin
            n_sb2.rej = ST_LEFT;
        end else begin
            n_sb2.rej = ST_OK;
        end
    end

    logic                  w_vld2;
    t_sb2                  w_sb2;
    logic signed [M2W-1:0] w_dp;
    logic signed [M2W-1:0] w_bq;
    logic signed [M2W-1:0] w_aq;
    logic signed [M2W-1:0] w_cp;

    cef_mul #(.AW(DFW), .BW(PQW), .SW($bits(t_sb2))) u_mul_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_sb.d), .i_b(r2_p), .i_side(n_sb2),
        .o_vld(w_vld2), .o_p(w_dp), .o_side(w_sb2)
    );
    cef_mul #(.AW(DFW), .BW(PQW), .SW(1)) u_mul_bq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_sb.b), .i_b(r2_q), .i_side(1'b0),
        .o_vld(), .o_p(w_bq), .o_side()
    );
    cef_mul #(.AW(DFW), .BW(PQW), .SW(1)) u_mul_aq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_sb.a), .i_b(r2_q), .i_side(1'b0),
        .o_vld(), .o_p(w_aq), .o_side()
    );
    cef_mul #(.AW(DFW), .BW(PQW), .SW(1)) u_mul_cp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r2_vld),
        .i_a(r2_sb.c), .i_b(r2_p), .i_side(1'b0),
        .o_vld(), .o_p(w_cp), .o_side()
    );

    // Rounded quotient set-up: t = 2N + H over 2H with H = -2K.
    logic                  r3_vld;
    t_sb3                  r3_sb;
    logic signed [NNW-1:0] r3_nx;
    logic signed [NNW-1:0] r3_ny;
    logic [DNW-1:0]        r3_h;
    logic                  r4_vld;
    t_sb3                  r4_sb;
    logic signed [TW-1:0]  r4_tx;
    logic signed [TW-1:0]  r4_ty;
    logic [DNW-1:0]        r4_d2;
    logic                  r5_vld;
    t_sb4                  r5_sb;
    logic [TW-1:0]         r5_mx;
    logic [TW-1:0]         r5_my;
    logic [DNW-1:0]        r5_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r3_vld <= w_vld2;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_sb.ax   <= w_sb2.ax;
        r3_sb.ay   <= w_sb2.ay;
        r3_sb.rej  <= w_sb2.rej;
        r3_nx      <= NNW'(w_bq) - NNW'(w_dp);
        r3_ny      <= NNW'(w_cp) - NNW'(w_aq);
        r3_h       <= ~{w_sb2.k, 1'b0} + DNW'(1);
        r4_sb      <= r3_sb;
        r4_tx      <= {r3_nx, 1'b0} + TW'(r3_h);
        r4_ty      <= {r3_ny, 1'b0} + TW'(r3_h);
        r4_d2      <= {r3_h[DNW-2:0], 1'b0};
        r5_sb.ax   <= r4_sb.ax;
        r5_sb.ay   <= r4_sb.ay;
        r5_sb.rej  <= r4_sb.rej;
        r5_sb.negx <= r4_tx[TW-1];
        r5_sb.negy <= r4_ty[TW-1];
        r5_mx      <= r4_tx[TW-1] ? (~r4_tx + TW'(r4_d2)) : r4_tx;
        r5_my      <= r4_ty[TW-1] ? (~r4_ty + TW'(r4_d2)) : r4_ty;
        r5_d2      <= r4_d2;
    end

    logic          w_vld4;
    t_sb4          w_sb4;
    logic [TW-1:0] w_qx;
    logic [TW-1:0] w_qy;

    cef_div #(.NW(TW), .DW(DNW), .SW($bits(t_sb4))) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r5_vld),
        .i_n(r5_mx), .i_d(r5_d2), .i_side(r5_sb),
        .o_vld(w_vld4), .o_q(w_qx), .o_side(w_sb4)
    );
    cef_div #(.NW(TW), .DW(DNW), .SW(1)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r5_vld),
        .i_n(r5_my), .i_d(r5_d2), .i_side(1'b0),
        .o_vld(), .o_q(w_qy), .o_side()
    );

    // Signed center offsets, then their squares.
    logic r6_vld;
    t_sb5 r6_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= w_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_sb.ax  <= w_sb4.ax;
        r6_sb.ay  <= w_sb4.ay;
        r6_sb.rej <= w_sb4.rej;
        r6_sb.dx  <= w_sb4.negx ? -w_qx[DXW-1:0] : w_qx[DXW-1:0];
        r6_sb.dy  <= w_sb4.negy ? -w_qy[DXW-1:0] : w_qy[DXW-1:0];
    end

    logic                 w_vld5;
    t_sb5                 w_sb5;
    logic signed [XW-1:0] w_sqx;
    logic signed [XW-1:0] w_sqy;

    cef_mul #(.AW(DXW), .BW(DXW), .SW($bits(t_sb5))) u_mul_sqx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r6_vld),
        .i_a(r6_sb.dx), .i_b(r6_sb.dx), .i_side(r6_sb),
        .o_vld(w_vld5), .o_p(w_sqx), .o_side(w_sb5)
    );
    cef_mul #(.AW(DXW), .BW(DXW), .SW(1)) u_mul_sqy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r6_vld),
        .i_a(r6_sb.dy), .i_b(r6_sb.dy), .i_side(1'b0),
        .o_vld(), .o_p(w_sqy), .o_side()
    );

    logic          r8_vld;
    logic [XW-1:0] r8_s;
    t_sb6          r8_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= w_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_s      <= w_sqx + w_sqy;
        r8_sb.ox  <= OW'(w_sb5.ax) + OW'(w_sb5.dx);
        r8_sb.oy  <= OW'(w_sb5.ay) + OW'(w_sb5.dy);
        r8_sb.rej <= w_sb5.rej;
    end

    // Radius and rightmost point.
    logic          w_vld6;
    t_sb6          w_sb6;
    logic [RW-1:0] w_r;

    cef_sqrt #(.XW(XW), .SW($bits(t_sb6))) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r8_vld),
        .i_x(r8_s), .i_side(r8_sb),
        .o_vld(w_vld6), .o_r(w_r), .o_side(w_sb6)
    );

    logic                  r9_vld;
    logic signed [EXW-1:0] r9_ox;
    logic signed [EXW-1:0] r9_oy;
    logic signed [EXW-1:0] r9_ex;
    t_cef_status           r9_rej;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= w_vld6;
        end
    end

    always_ff @(posedge i_clk) begin
        r9_ox  <= EXW'(w_sb6.ox);
        r9_oy  <= EXW'(w_sb6.oy);
        r9_ex  <= EXW'(w_sb6.ox) + EXW'(w_r);
        r9_rej <= w_sb6.rej;
    end

    // Saturation and result register.
    logic [W:0] w_cx;
    logic [W:0] w_cy;
    logic [W:0] w_ex;
    t_cef_out   n_out;
    logic       r_ovld;
    t_cef_out   r_out;

    assign w_cx = f_clamp(r9_ox);
    assign w_cy = f_clamp(r9_oy);
    assign w_ex = f_clamp(r9_ex);

    always_comb begin
        if (r9_rej != ST_OK) begin
            n_out.status   = r9_rej;
            n_out.center_x = '0;
            n_out.center_y = '0;
            n_out.event_x  = '0;
        end else begin
            n_out.status   = (w_cx[W] || w_cy[W] || w_ex[W]) ? ST_SAT : ST_OK;
            n_out.center_x = w_cx[W-1:0];
            n_out.center_y = w_cy[W-1:0];
            n_out.event_x  = w_ex[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_ovld;
    assign o_result = r_out;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result transfer right after reset");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == ST_LEFT || o_result.status == ST_COLLINEAR)
        |-> o_result.center_x == '0 && o_result.center_y == '0 && o_result.event_x == '0)
        else $error("rejected triple carries nonzero coordinates");

    a_event_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r9_vld && r9_rej == ST_OK |-> r9_ex >= r9_ox)
        else $error("event point lies left of the circumcenter");

endmodule
`default_nettype wire

FILE: hw/rtl/cef_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Splits both magnitudes into limbs and adds one limb product per stage into
// a running sum, then restores the sign. A side vector travels along.
// ----------------------------------------------------------------------------
module cef_mul
    import cef_pkg::*;
#(
    parameter int AW = COORD_BITS + 1,
    parameter int BW = COORD_BITS + 1,
    parameter int SW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    input  logic [SW-1:0]           i_side,
    output logic                    o_vld,
    output logic signed [AW+BW-1:0] o_p,
    output logic [SW-1:0]           o_side
);

    localparam int L  = LIMB_BITS;
    localparam int NA = (AW + L - 1) / L;
    localparam int NB = (BW + L - 1) / L;
    localparam int NP = NA * NB;
    localparam int NS = NP + 1;
    localparam int EW = (NA + NB) * L;
    localparam int PW = AW + BW;

    logic            r_vld  [0:NS];
    logic            r_neg  [0:NS];
    logic [SW-1:0]   r_side [0:NS];
    logic [NA*L-1:0] r_ma   [0:NS];
    logic [NB*L-1:0] r_mb   [0:NS];
    logic [EW-1:0]   r_acc  [0:NS];
    logic [2*L-1:0]  r_pp   [0:NS];
    logic            r_ovld;
    logic [PW-1:0]   r_p;
    logic [SW-1:0]   r_oside;
    logic [AW-1:0]   n_ma;
    logic [BW-1:0]   n_mb;
    logic [PW-1:0]   n_mag;

    assign n_ma = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign n_mb = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg[0]  <= i_a[AW-1] ^ i_b[BW-1];
        r_side[0] <= i_side;
        r_ma[0]   <= (NA*L)'(n_ma);
        r_mb[0]   <= (NB*L)'(n_mb);
        r_acc[0]  <= '0;
        r_pp[0]   <= '0;
    end

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        localparam int PI = k - 1;
        localparam int IA = (PI < NP) ? (PI / NB) : 0;
        localparam int IB = (PI < NP) ? (PI % NB) : 0;
        localparam int QP = (k >= 2) ? (k - 2) : 0;
        localparam int SH = L * (QP / NB + QP % NB);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[k]  <= r_neg[k-1];
            r_side[k] <= r_side[k-1];
            r_ma[k]   <= r_ma[k-1];
            r_mb[k]   <= r_mb[k-1];
            r_acc[k]  <= r_acc[k-1] + (EW'(r_pp[k-1]) << SH);
            if (PI < NP) begin
                r_pp[k] <= r_ma[k-1][IA*L +: L] * r_mb[k-1][IB*L +: L];
            end else begin
                r_pp[k] <= '0;
            end
        end
    end

    assign n_mag = r_acc[NS][PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= r_neg[NS] ? (~n_mag + PW'(1)) : n_mag;
        r_oside <= r_side[NS];
    end

    assign o_vld  = r_ovld;
    assign o_p    = r_p;
    assign o_side = r_oside;

endmodule
`default_nettype wire

FILE: hw/rtl/cef_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division that settles one quotient bit per stage, most
// significant bit first. A side vector travels along.
// ----------------------------------------------------------------------------
module cef_div
    import cef_pkg::*;
#(
    parameter int NW = 3 * COORD_BITS + 6,
    parameter int DW = 2 * COORD_BITS + 4,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_n,
    input  logic [DW-1:0] i_d,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_q,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [0:NW];
    logic [SW-1:0] r_side [0:NW];
    logic [NW-1:0] r_n    [0:NW];
    logic [DW-1:0] r_d    [0:NW];
    logic [DW-1:0] r_rem  [0:NW];
    logic [NW-1:0] r_q    [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_n[0]    <= i_n;
        r_d[0]    <= i_d;
        r_rem[0]  <= '0;
        r_q[0]    <= '0;
    end

    for (genvar k = 1; k <= NW; k++) begin : g_stage
        localparam int BIT = NW - k;
        logic [DW:0]   w_sh;
        logic [DW+1:0] w_df;
        logic          w_ge;
        logic [NW-1:0] n_q;

        assign w_sh = {r_rem[k-1], r_n[k-1][BIT]};
        assign w_df = {1'b0, w_sh} - {2'b00, r_d[k-1]};
        assign w_ge = ~w_df[DW+1];

        always_comb begin
            n_q      = r_q[k-1];
            n_q[BIT] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= r_side[k-1];
            r_n[k]    <= r_n[k-1];
            r_d[k]    <= r_d[k-1];
            r_rem[k]  <= w_ge ? w_df[DW-1:0] : w_sh[DW-1:0];
            r_q[k]    <= n_q;
        end
    end

    assign o_vld  = r_vld[NW];
    assign o_q    = r_q[NW];
    assign o_side = r_side[NW];

endmodule
`default_nettype wire

FILE: hw/rtl/cef_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root that settles one root bit per stage from
// two radicand bits. A side vector travels along.
// ----------------------------------------------------------------------------
module cef_sqrt
    import cef_pkg::*;
#(
    parameter int XW = 6 * COORD_BITS + 6,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [XW-1:0]   i_x,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [XW/2-1:0] o_r,
    output logic [SW-1:0]   o_side
);

    localparam int RW = XW / 2;

    logic          r_vld  [0:RW];
    logic [SW-1:0] r_side [0:RW];
    logic [XW-1:0] r_x    [0:RW];
    logic [RW+1:0] r_rem  [0:RW];
    logic [RW-1:0] r_root [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        r_x[0]    <= i_x;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar k = 1; k <= RW; k++) begin : g_stage
        localparam int BIT = XW - 2 * k;
        logic [RW+3:0] w_sh;
        logic [RW+3:0] w_trial;
        logic [RW+4:0] w_df;
        logic          w_ge;

        assign w_sh    = {r_rem[k-1], r_x[k-1][BIT+1 -: 2]};
        assign w_trial = (RW+4)'({r_root[k-1], 2'b01});
        assign w_df    = {1'b0, w_sh} - {1'b0, w_trial};
        assign w_ge    = ~w_df[RW+4];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= r_side[k-1];
            r_x[k]    <= r_x[k-1];
            r_rem[k]  <= w_ge ? w_df[RW+1:0] : w_sh[RW+1:0];
            r_root[k] <= {r_root[k-1][RW-2:0], w_ge};
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_r    = r_root[RW];
    assign o_side = r_side[RW];

endmodule
`default_nettype wire

FILE: sim/circle_event_from_three_sites_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle event from three sites testbench
// Sends directed and random site triples with random gaps between transfers,
// none in some runs of the random test. Each accepted triple gets its
// circumcenter, rightmost circle point and status worked out in wide integer
// arithmetic. Each result is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module circle_event_from_three_sites_test;
    import cef_pkg::*;

    typedef logic signed [255:0] t_big;

    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   DRAIN_CYCLES   = 400;
    localparam t_big COORD_MAX      = 256'sd2147483647;
    localparam t_big COORD_MIN      = -256'sd2147483648;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_cef_in  i_item  = '0;
    logic     o_valid;
    t_cef_out o_result;

    t_cef_out pending_events[$];
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       no_gaps     = 1'b0;

    circle_event_from_three_sites dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Rounds num / den to nearest, ties up; den is positive.
    function automatic t_big round_div(t_big num, t_big den);
        t_big t;
        t_big d2;
        t = 2 * num + den;
        d2 = 2 * den;
        if (t < 0) begin
            return -((-t + d2 - 1) / d2);
        end
        return t / d2;
    endfunction

    function automatic t_big floor_sqrt(t_big v);
        logic [255:0] root;
        logic [255:0] cand;
        root = '0;
        for (int i = 127; i >= 0; i--) begin
            cand = root | (256'd1 << i);
            if (cand * cand <= v) begin
                root = cand;
            end
        end
        return root;
    endfunction

    function automatic t_coord clamp_coord(t_big v, ref bit sat);
        if (v > COORD_MAX) begin
            sat = 1'b1;
            return COORD_MAX[31:0];
        end
        if (v < COORD_MIN) begin
            sat = 1'b1;
            return COORD_MIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic t_cef_out predict_event(t_cef_in x);
        t_big     ax, ay, a, b, c, d, k, p, q, num_x, num_y, dx, dy, ox, oy, radius;
        t_cef_out res;
        bit       sat;
        ax = $signed(x.ax);
        ay = $signed(x.ay);
        a = $signed(x.bx) - ax;
        b = $signed(x.by) - ay;
        c = $signed(x.cx) - ax;
        d = $signed(x.cy) - ay;
        k = a * d - b * c;
        res = '0;
        sat = 1'b0;
        if (k == 0) begin
            res.status = ST_COLLINEAR;
            return res;
        end
        if (k > 0) begin
            res.status = ST_LEFT;
            return res;
        end
        p = a * a + b * b;
        q = c * c + d * d;
        num_x = d * p - b * q;
        num_y = a * q - c * p;
        dx = round_div(-num_x, -2 * k);
        dy = round_div(-num_y, -2 * k);
        ox = ax + dx;
        oy = ay + dy;
        radius = floor_sqrt(dx * dx + dy * dy);
        res.center_x = clamp_coord(ox, sat);
        res.center_y = clamp_coord(oy, sat);
        res.event_x = clamp_coord(ox + radius, sat);
        res.status = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    task automatic send_triple(t_cef_in x);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= x;
        do @(posedge i_clk); while (busy);
        pending_events.insert(pending_events.size(), predict_event(x));
    endtask

    task automatic send_sites(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                              t_coord cx, t_coord cy);
        t_cef_in x;
        x = '{ax, ay, bx, by, cx, cy};
        send_triple(x);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_coord mx;
        t_coord mn;
        mx = COORD_MAX[31:0];
        mn = COORD_MIN[31:0];
        send_sites(0, 0, 0, 65536, 65536, 0);
        send_sites(0, 0, 65536, 0, 0, 65536);
        send_sites(0, 0, 65536, 65536, 131072, 131072);
        send_sites(7, 7, 7, 7, 7, 7);
        send_sites(5, 9, 5, 9, -3, 2);
        send_sites(mn, mn, mn, mx, mx, mn);
        send_sites(mn, mn, mx, mn, mn, mx);
        send_sites(mx, mx, mx, mn, mn, mx);
        send_sites(mx, mx, mn, mx, mx, mn);
        send_sites(mn, mn, mn, mn, mx, mx);
        send_sites(0, 0, 1, 1, 2, 1);
        send_sites(0, 0, mx, 1, mn, 0);
        send_sites(0, 0, mx, 0, mx, -1);
        send_sites(mn, 0, mx, 1, 0, 0);
        send_sites(-1, -1, -1, 0, 0, -1);
        send_sites(mx, 0, mx - 1, 1, mx, 1);
        send_sites(3, 0, 0, 3, 0, -3);
        send_sites(-3, 0, 0, -3, 0, 3);
        send_sites(0, 0, 0, 2, 1, 1);
        send_sites(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                   32'sh0F0F_0F0F, 32'shF0F0_F0F0);
    endtask

    function automatic t_coord rand_span(int bits);
        logic [31:0] r;
        r = $urandom();
        if (bits >= 32) begin
            return r;
        end
        return $signed(r) >>> (32 - bits);
    endfunction

    task automatic test_random(int count);
        t_cef_in x;
        t_coord  tmp;
        int      kind;
        int      bits;
        int      s;
        int      t;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 9);
            bits = $urandom_range(2, 32);
            if (kind <= 1) begin
                x = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom()};
            end else if (kind <= 7) begin
                x.ax = rand_span(bits);
                x.ay = rand_span(bits);
                x.bx = rand_span(bits);
                x.by = rand_span(bits);
                x.cx = rand_span(bits);
                x.cy = rand_span(bits);
                if (predict_event(x).status == ST_LEFT) begin
                    tmp = x.bx; x.bx = x.cx; x.cx = tmp;
                    tmp = x.by; x.by = x.cy; x.cy = tmp;
                end
            end else begin
                x.ax = rand_span(20);
                x.ay = rand_span(20);
                s = $urandom_range(0, 2047) - 1024;
                t = $urandom_range(0, 2047) - 1024;
                x.bx = x.ax + s * rand_span(12);
                x.by = x.ay + s * rand_span(12);
                x.cx = x.ax + t * ((x.bx - x.ax) / (s == 0 ? 1 : s));
                x.cy = x.ay + t * ((x.by - x.ay) / (s == 0 ? 1 : s));
                if (kind == 9) begin
                    x.cx = x.cx + ($urandom_range(0, 1) ? 1 : -1);
                end
            end
            send_triple(x);
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_cef_out want;
        if (i_rst_n && o_valid) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_result);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_result.status);
                    error_count++;
                end
                if (o_result.center_x !== want.center_x) begin
                    $display("%0t: center_x expected %h actual %h", $time,
                             want.center_x, o_result.center_x);
                    error_count++;
                end
                if (o_result.center_y !== want.center_y) begin
                    $display("%0t: center_y expected %h actual %h", $time,
                             want.center_y, o_result.center_y);
                    error_count++;
                end
                if (o_result.event_x !== want.event_x) begin
                    $display("%0t: event_x expected %h actual %h", $time,
                             want.event_x, o_result.event_x);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_until_drained();
        test_random(1000);
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
